FILE: rtl/sync_frame_receiver_checksum_unit_defines.svh
// Assertion macros shared by the RTL of the sync frame receiver.
// Define ASSERT_OFF to compile every assertion away.
`ifndef SYNC_FRAME_RECEIVER_CHECKSUM_UNIT_DEFINES_SVH
`define SYNC_FRAME_RECEIVER_CHECKSUM_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked at every rising edge outside reset.
`define SFRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define SFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SFRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SFRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: rtl/sfrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfrc_pkg;

	localparam logic [7:0] SYNC_FIRST    = 8'h21;
	localparam logic [7:0] SYNC_SECOND   = 8'h47;
	localparam logic [3:0] FULL_LENGTH   = 4'd15;
	localparam logic [3:0] CHECK_INDEX   = 4'd14;
	localparam logic [3:0] FIRST_PAYLOAD = 4'd2;
	localparam int         PAYLOAD_BYTES = 12;
	localparam int         SLOT_W        = $clog2(PAYLOAD_BYTES);

	localparam logic [3:0] LIMIT_RESET   = 4'd15;
	localparam logic [3:0] LIMIT_MIN     = 4'd1;

	// Register index, taken from paddr[2] (registers sit on 4-byte steps).
	localparam logic REG_BUFFER_LIMIT = 1'b0;

	typedef enum logic [1:0] {
		PHASE_HUNT    = 2'd0,
		PHASE_SYNC2   = 2'd1,
		PHASE_COLLECT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		STATUS_OK         = 2'd0,
		STATUS_BAD_LENGTH = 2'd1,
		STATUS_BAD_CHECK  = 2'd2
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  frame_length;
		logic [31:0] payload_x;
		logic [31:0] payload_y;
		logic [31:0] payload_z;
		logic [7:0]  check_byte;
	} frame_result_t;

endpackage

`default_nettype wire

FILE: rtl/sync_frame_receiver_checksum_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Sync-prefix frame receiver with an inverted-sum check byte.
// Input channel: one received byte per transaction on rx_byte, in_valid / in_stall.
// The receiver hunts for '!' then 'G', then collects bytes until 15 are held or
// the count reaches buffer_limit (APB register 0, reset 15, 0 acts as 1).
// Output channel: one transaction per closed frame on status, frame_length,
// payload_x/y/z and check_byte, out_valid / out_stall.
// A result is written to the output register when the closing byte is accepted,
// or to the skid register while the output register holds a stalled result.
// Throughput: one byte per cycle while in_stall is low.
// A stalled result holds in the output register; one more result fits in a
// skid register, and in_stall rises only while that skid register is full,
// so bytes that close no frame keep flowing while the receiver stalls.
// Reset clears the hunt state, the byte count, both valid flags and sets
// buffer_limit to 15. Write buffer_limit only while the block is idle.
// prdata returns buffer_limit in its low four bits; pready is tied high.

`include "sync_frame_receiver_checksum_unit_defines.svh"

module sync_frame_receiver_checksum_unit
	import sfrc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	// byte input
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  rx_byte,
	// frame result
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [1:0]  status,
	output      logic [3:0]  frame_length,
	output      logic [31:0] payload_x,
	output      logic [31:0] payload_y,
	output      logic [31:0] payload_z,
	output      logic [7:0]  check_byte
);

	// receiver state
	phase_t      phase_q, phase_d;
	logic [3:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  check_q, check_d;
	logic [7:0]  payload_q [PAYLOAD_BYTES];
	logic [7:0]  payload_d [PAYLOAD_BYTES];
	logic [3:0]  limit_q;

	// output register and skid register
	logic          out_valid_q;
	frame_result_t out_q;
	logic          skid_valid_q;
	frame_result_t skid_q;

	logic          in_acc;
	logic          out_take;
	logic          step_ok;
	logic          emit;
	logic [3:0]    count_step;
	logic [3:0]    limit_eff;
	logic [3:0]    slot_full;
	logic [SLOT_W-1:0] slot;
	frame_result_t result;
	logic          cfg_wr;

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign out_take = out_valid_q && !out_stall;

	// ---------------------------------------------------------------
	// Configuration: one register, written in the APB access phase.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BUFFER_LIMIT);

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_BUFFER_LIMIT) begin
			prdata = {28'd0, limit_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[3:0];
		end
	end

	// ---------------------------------------------------------------
	// Next state for one byte, plus the result of a closing byte.
	// ---------------------------------------------------------------
	assign limit_eff = (limit_q == 4'd0) ? LIMIT_MIN : limit_q;
	assign slot_full = count_q - FIRST_PAYLOAD;
	assign slot      = slot_full[SLOT_W-1:0];

	always_comb begin
		phase_d    = phase_q;
		count_step = count_q;
		sum_d      = sum_q;
		check_d    = check_q;
		payload_d  = payload_q;
		step_ok    = 1'b0;

		case (phase_q)
			PHASE_HUNT: begin
				if (rx_byte == SYNC_FIRST) begin
					// frame start: wipe what the last frame left
					for (int k = 0; k < PAYLOAD_BYTES; k++) begin
						payload_d[k] = '0;
					end
					check_d    = '0;
					sum_d      = rx_byte;
					count_step = 4'd1;
					phase_d    = PHASE_SYNC2;
					step_ok    = 1'b1;
				end
			end
			PHASE_SYNC2: begin
				if (rx_byte == SYNC_SECOND) begin
					sum_d      = sum_q + rx_byte;
					count_step = 4'd2;
					phase_d    = PHASE_COLLECT;
					step_ok    = 1'b1;
				end
			end
			PHASE_COLLECT: begin
				if (count_q < CHECK_INDEX) begin
					sum_d = sum_q + rx_byte;
					if (count_q >= FIRST_PAYLOAD) begin
						payload_d[slot] = rx_byte;
					end
				end else if (count_q == CHECK_INDEX) begin
					check_d = rx_byte;
				end
				count_step = count_q + 4'd1;
				step_ok    = 1'b1;
			end
			default: begin
				step_ok = 1'b0;
			end
		endcase

		emit = step_ok && ((count_step >= FULL_LENGTH) || (count_step >= limit_eff));

		// drop a byte that breaks sync, or close the frame: hunt again
		count_d = count_step;
		if (!step_ok || emit) begin
			phase_d = PHASE_HUNT;
			count_d = '0;
		end

		if (count_step != FULL_LENGTH) begin
			result.status = STATUS_BAD_LENGTH;
		end else if (~sum_d != check_d) begin
			result.status = STATUS_BAD_CHECK;
		end else begin
			result.status = STATUS_OK;
		end
		result.frame_length = count_step;
		result.payload_x    = {payload_d[3], payload_d[2], payload_d[1], payload_d[0]};
		result.payload_y    = {payload_d[7], payload_d[6], payload_d[5], payload_d[4]};
		result.payload_z    = {payload_d[11], payload_d[10], payload_d[9], payload_d[8]};
		result.check_byte   = check_d;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_HUNT;
			count_q <= '0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	// frame contents: cleared at every frame start before any read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sum_q     <= sum_d;
			check_q   <= check_d;
			payload_q <= payload_d;
		end
	end

	// ---------------------------------------------------------------
	// Output register with one skid entry behind it.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// no byte is taken while the skid entry is full
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (in_acc && emit) begin
			if (out_valid_q && !out_take) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (in_acc && emit) begin
			if (out_valid_q && !out_take) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_q.status;
	assign frame_length = out_q.frame_length;
	assign payload_x    = out_q.payload_x;
	assign payload_y    = out_q.payload_y;
	assign payload_z    = out_q.payload_z;
	assign check_byte   = out_q.check_byte;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	// the skid entry only fills behind a held result
	`SFRC_ASSERT_IMPL(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid full with empty output register")
	// a result that meets a stalled output lands in the skid entry
	`SFRC_ASSERT_NEXT(a_skid_catch, clk, arst_n, in_acc && emit && out_valid_q && out_stall, skid_valid_q, "closing result lost on stall")
	// while hunting no byte is counted
	`SFRC_ASSERT_IMPL(a_hunt_count, clk, arst_n, phase_q == PHASE_HUNT, count_q == 4'd0, "count not zero while hunting")
	// collection resumes at byte two and never passes the check byte
	`SFRC_ASSERT_IMPL(a_collect_range, clk, arst_n, phase_q == PHASE_COLLECT, count_q >= FIRST_PAYLOAD && count_q <= CHECK_INDEX, "collect count out of range")

endmodule

`default_nettype wire

FILE: sim/sync_frame_receiver_checksum_unit_test.sv
`timescale 1ns / 1ps

module sync_frame_receiver_checksum_unit_test;
	import sfrc_pkg::*;

	localparam int IDLE_PCT     = 31;     // chance in a hundred that a side idles in a cycle
	localparam int RANDOM_ITEMS = 600;    // bytes taken into frames by the random part
	localparam int DRAIN        = 4;      // output register plus skid register, with margin
	localparam int MAX_PRINTED  = 40;
	localparam logic [2:0] LIMIT_ADDR = {REG_BUFFER_LIMIT, 2'b00};

	// One row of the directed table: optionally set the limit first, then send a
	// byte. Rows marked typed carry a result read straight off the frame format.
	typedef struct {
		bit            set_limit;
		logic [3:0]    limit;
		logic [7:0]    data;
		bit            typed;
		frame_result_t want;
	} probe_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [3:0]  frame_length;
	logic [31:0] payload_x;
	logic [31:0] payload_y;
	logic [31:0] payload_z;
	logic [7:0]  check_byte;

	// Frame receiver state as this bench predicts it.
	logic [3:0]    limit_now = LIMIT_RESET;
	phase_t        rx_phase = PHASE_HUNT;
	logic [3:0]    held = '0;
	logic [7:0]    sum8 = '0;
	logic [7:0]    frame_bytes [PAYLOAD_BYTES] = '{default: 8'h00};
	logic [7:0]    chk = '0;

	frame_result_t pending_frames [$];
	probe_row_t    probe_rows [$];
	bit            quiet = 1'b0;
	int            mismatches = 0;
	int            frames_checked = 0;
	int            taken_bytes = 0;
	int            limit_writes = 0;

	sync_frame_receiver_checksum_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.frame_length (frame_length),
		.payload_x    (payload_x),
		.payload_y    (payload_y),
		.payload_z    (payload_z),
		.check_byte   (check_byte)
	);

	always #1 clk = ~clk;

	// Hard stop in case the block hangs a handshake.
	initial begin
		#200000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic flag(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// Advance the predicted receiver by one accepted byte. Returns 1 when the
	// byte closes a frame, with the frame result in r.
	function automatic bit absorb_byte(input logic [7:0] b, output frame_result_t r);
		logic [3:0] eff_limit;
		logic [7:0] inv_sum;
		eff_limit = (limit_now == 4'd0) ? LIMIT_MIN : limit_now;
		r = '0;
		if (rx_phase == PHASE_HUNT && b == SYNC_FIRST) begin
			// frame start: wipe what the previous frame left behind
			frame_bytes = '{default: 8'h00};
			chk = 8'h00;
			sum8 = b;
			held = 4'd1;
			rx_phase = PHASE_SYNC2;
		end else if (rx_phase == PHASE_SYNC2 && b == SYNC_SECOND) begin
			sum8 = sum8 + b;
			held = 4'd2;
			rx_phase = PHASE_COLLECT;
		end else if (rx_phase == PHASE_COLLECT) begin
			if (held < CHECK_INDEX) begin
				sum8 = sum8 + b;
				if (held >= FIRST_PAYLOAD)
					frame_bytes[held - FIRST_PAYLOAD] = b;
			end else if (held == CHECK_INDEX) begin
				chk = b;
			end
			held = held + 4'd1;
		end else begin
			// lost sync: drop the byte and hunt again
			rx_phase = PHASE_HUNT;
			held = 4'd0;
			return 1'b0;
		end
		taken_bytes++;

		// the close test runs after every taken byte, sync bytes included
		if (held < FULL_LENGTH && held < eff_limit)
			return 1'b0;

		inv_sum = ~sum8;
		if (held != FULL_LENGTH)
			r.status = STATUS_BAD_LENGTH;
		else if (inv_sum != chk)
			r.status = STATUS_BAD_CHECK;
		else
			r.status = STATUS_OK;
		r.frame_length = held;
		r.payload_x = {frame_bytes[3], frame_bytes[2], frame_bytes[1], frame_bytes[0]};
		r.payload_y = {frame_bytes[7], frame_bytes[6], frame_bytes[5], frame_bytes[4]};
		r.payload_z = {frame_bytes[11], frame_bytes[10], frame_bytes[9], frame_bytes[8]};
		r.check_byte = chk;
		rx_phase = PHASE_HUNT;
		held = 4'd0;
		return 1'b1;
	endfunction

	// Bytes biased toward the sync values and the extremes.
	function automatic logic [7:0] any_byte();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return SYNC_FIRST;
		if (r < 13)
			return SYNC_SECOND;
		if (r < 18)
			return 8'h00;
		if (r < 23)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	// Send one byte; entered and left at a rising edge. On acceptance, queue the
	// frame result it closes, if any. A typed row overrides the prediction.
	task automatic send(input logic [7:0] b, input bit typed = 1'b0,
			input frame_result_t want = '0);
		frame_result_t r;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (absorb_byte(b, r) || typed)
			pending_frames.push_back(typed ? want : r);
	endtask

	// Change buffer_limit only with the receiver drained, then read it back.
	task automatic write_limit(input logic [3:0] v);
		in_valid <= 1'b0;
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= {28'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		limit_now = v;
		limit_writes++;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[3:0] !== v)
			flag($sformatf("buffer_limit read back %0d, wrote %0d", prdata[3:0], v));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_row(input bit set_limit, input logic [3:0] limit,
			input logic [7:0] data, input bit typed = 1'b0, input frame_result_t want = '0);
		probe_row_t row;
		row.set_limit = set_limit;
		row.limit = limit;
		row.data = data;
		row.typed = typed;
		row.want = want;
		probe_rows.push_back(row);
	endtask

	// Receiver side: stall at random, except through the quiet stretch.
	always @(posedge clk)
		out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);

	// Score every frame result taken from the block against the oldest expectation.
	always @(posedge clk) begin : score
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				flag("frame result with none expected");
			end else begin
				want = pending_frames.pop_front();
				frames_checked++;
				if (status !== want.status)
					flag($sformatf("status %0d, expected %0d", status, want.status));
				if (frame_length !== want.frame_length)
					flag($sformatf("frame_length %0d, expected %0d",
						frame_length, want.frame_length));
				if (payload_x !== want.payload_x)
					flag($sformatf("payload_x %h, expected %h", payload_x, want.payload_x));
				if (payload_y !== want.payload_y)
					flag($sformatf("payload_y %h, expected %h", payload_y, want.payload_y));
				if (payload_z !== want.payload_z)
					flag($sformatf("payload_z %h, expected %h", payload_z, want.payload_z));
				if (check_byte !== want.check_byte)
					flag($sformatf("check_byte %h, expected %h", check_byte, want.check_byte));
			end
		end
	end

	initial begin : stimulus
		logic [3:0] settings [$];
		logic [7:0] acc;
		int i;
		int k;
		int n;
		int p;
		int plan;
		int target;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, run at the reset limit of 15 until the first limit row.
		add_row(0, 4'd0, 8'h00);                 // noise while hunting: drop
		add_row(0, 4'd0, SYNC_FIRST);
		add_row(0, 4'd0, SYNC_FIRST);            // '!' while waiting for 'G': drop, rehunt
		add_row(0, 4'd0, SYNC_FIRST);
		add_row(0, 4'd0, SYNC_SECOND);
		for (i = 0; i < PAYLOAD_BYTES; i++)
			add_row(0, 4'd0, 8'hFF);
		// full frame of 0xFF payload: inverted sum of bytes 0..13 is 0xA3
		add_row(0, 4'd0, 8'hA3, 1, frame_result_t'{STATUS_OK, 4'd15,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hA3});
		// limit 1 closes on the '!' itself; payload was wiped at frame start
		add_row(1, 4'd1, SYNC_FIRST, 1, frame_result_t'{STATUS_BAD_LENGTH, 4'd1,
			32'd0, 32'd0, 32'd0, 8'd0});
		// a zero limit acts as one
		add_row(1, 4'd0, SYNC_FIRST, 1, frame_result_t'{STATUS_BAD_LENGTH, 4'd1,
			32'd0, 32'd0, 32'd0, 8'd0});
		add_row(1, 4'd2, SYNC_FIRST);
		add_row(0, 4'd0, SYNC_SECOND, 1, frame_result_t'{STATUS_BAD_LENGTH, 4'd2,
			32'd0, 32'd0, 32'd0, 8'd0});
		add_row(1, 4'd3, SYNC_FIRST);
		add_row(0, 4'd0, SYNC_SECOND);
		add_row(0, 4'd0, 8'h80, 1, frame_result_t'{STATUS_BAD_LENGTH, 4'd3,
			32'h0000_0080, 32'd0, 32'd0, 8'd0});

		foreach (probe_rows[i]) begin
			if (probe_rows[i].set_limit)
				write_limit(probe_rows[i].limit);
			send(probe_rows[i].data, probe_rows[i].typed, probe_rows[i].want);
		end

		// Random part: one limit setting per leg, the fourth leg with no idling.
		settings = '{4'd15, 4'd1, 4'd0, 4'd15, 4'd2, 4'd14, 4'd7, 4'd15, 4'd3, 4'd13};
		for (p = 0; p < settings.size(); p++) begin
			write_limit(settings[p]);
			quiet = (p == 3);
			target = taken_bytes + RANDOM_ITEMS / settings.size();
			while (taken_bytes < target) begin
				plan = $urandom_range(99);
				if (plan < 70) begin
					// well-formed frame, mostly full length, check byte right half the time
					n = ($urandom_range(9) == 0) ? $urandom_range(1, PAYLOAD_BYTES - 1)
						: PAYLOAD_BYTES;
					send(SYNC_FIRST);
					send(SYNC_SECOND);
					acc = SYNC_FIRST + SYNC_SECOND;
					for (k = 0; k < n; k++) begin
						i = any_byte();
						acc = acc + i[7:0];
						send(i[7:0]);
					end
					if (n == PAYLOAD_BYTES)
						send($urandom_range(1) ? ~acc : any_byte());
				end else if (plan < 85) begin
					// broken sync pair
					send(SYNC_FIRST);
					send(any_byte());
				end else begin
					repeat ($urandom_range(1, 4)) send(any_byte());
				end
			end
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		// Drain: wait out every queued frame, then the pipeline depth.
		while (pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Covered %0d bytes taken into frames and %0d frame results compared,",
			taken_bytes, frames_checked);
		$display("across %0d buffer_limit writes including limits 0, 1 and 15.",
			limit_writes);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
